// ===== src/tct_pkg.sv =====
// shared types and constants for the tcp connection tracker
// no dependencies; imported by tct_front, tct_back and tcp_connection_tracker
package tct_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] FLAG_FIN       = 8'h01;
	localparam logic [7:0] FLAG_SYN       = 8'h02;
	localparam logic [7:0] FLAG_RST       = 8'h04;
	localparam logic [7:0] FLAG_ACK       = 8'h10;
	localparam logic [7:0] FLAG_KIND_MASK = 8'h3F;
	localparam logic [7:0] FLAG_CLOSE     = FLAG_FIN | FLAG_RST;

	localparam logic [3:0] SCALE_ABSENT = 4'd15;

	typedef enum logic [1:0] {
		ST_SYN = 2'd0,
		ST_EST = 2'd1,
		ST_FIN = 2'd2
	} conn_state_t;

	// segment class worked out at the front
	typedef enum logic [2:0] {
		SEG_NONTCP = 3'd0,
		SEG_SYN    = 3'd1,
		SEG_SYNACK = 3'd2,
		SEG_CLOSE  = 3'd3,
		SEG_OTHER  = 3'd4
	} seg_kind_t;

	typedef struct packed {
		seg_kind_t   kind;
		logic        rev;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [31:0] ack_m1;
		logic [15:0] win;
		logic [3:0]  scale;
		logic [15:0] len;
		logic        has_data;
	} item_t;

	// queue handshake towards the back
	typedef struct packed {
		logic valid;
	} q_status_t;

endpackage

// ===== src/tct_front.sv =====
// front: accepts packet words, classifies the segment and queues it
// depends on tct_pkg
module tct_front import tct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_ready,
	input  logic        is_reverse,
	input  logic        is_tcp,
	input  logic [7:0]  tcp_flags,
	input  logic [31:0] seq_number,
	input  logic [31:0] ack_number,
	input  logic [15:0] window_field,
	input  logic [3:0]  scale_option,
	input  logic [15:0] payload_length,
	output q_status_t   q_status,
	input  logic        q_pop,
	output item_t       q_item
);

	item_t            queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            cls;
	logic [7:0]       kind_bits;
	logic             push;
	logic             pop;

	always_comb begin
		kind_bits = tcp_flags & FLAG_KIND_MASK;
		cls.rev      = is_reverse;
		cls.seq      = seq_number;
		cls.ack      = ack_number;
		cls.ack_m1   = ack_number - 32'd1;
		cls.win      = window_field;
		cls.scale    = scale_option;
		cls.len      = payload_length;
		cls.has_data = payload_length != 16'd0;
		if (!is_tcp) begin
			cls.kind = SEG_NONTCP;
		end else if (kind_bits == FLAG_SYN) begin
			cls.kind = SEG_SYN;
		end else if (kind_bits == (FLAG_SYN | FLAG_ACK)) begin
			cls.kind = SEG_SYNACK;
		end else if ((tcp_flags & FLAG_CLOSE) != 8'd0) begin
			cls.kind = SEG_CLOSE;
		end else begin
			cls.kind = SEG_OTHER;
		end
	end

	assign pkt_ready      = count_q != CNT_W'(QUEUE_DEPTH);
	assign push           = pkt_valid && pkt_ready;
	assign q_status.valid = count_q != '0;
	assign pop            = q_pop && q_status.valid;
	assign q_item         = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(QUEUE_DEPTH) |=> count_q != '0)
		else $error("queue count wrapped");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_status.valid)
		else $error("queued word not visible to back");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(1) && pop && !push |=> !q_status.valid)
		else $error("queue not empty after last word drained");

endmodule

// ===== src/tct_back.sv =====
// back: applies one queued segment per cycle unless its result is stalled; holds the result word
// depends on tct_pkg
module tct_back import tct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_status_t   q_status,
	output logic        q_pop,
	input  item_t       q_item,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  conn_state,
	output logic [31:0] initial_seq,
	output logic [31:0] initial_ack,
	output logic [31:0] last_seq,
	output logic [31:0] last_ack,
	output logic [31:0] orig_position,
	output logic [31:0] reply_position
);

	conn_state_t state_q, state_d;
	logic [31:0] orig_pkts_q, orig_pkts_d;
	logic [31:0] orig_data_q, orig_data_d;
	logic [31:0] reply_pkts_q, reply_pkts_d;
	logic [31:0] reply_data_q, reply_data_d;
	logic [31:0] seq_origin_q, seq_origin_d;
	logic [31:0] ack_origin_q, ack_origin_d;
	logic [31:0] seq_recent_q, seq_recent_d;
	logic [31:0] ack_recent_q, ack_recent_d;
	logic [31:0] pos_fwd_q, pos_fwd_d;
	logic [31:0] pos_bwd_q, pos_bwd_d;
	logic [15:0] win_fwd_q, win_fwd_d;
	logic [15:0] win_bwd_q, win_bwd_d;
	logic [3:0]  scale_fwd_q, scale_fwd_d;
	logic [3:0]  scale_bwd_q, scale_bwd_d;
	logic        res_valid_q;
	logic        clr;

	assign q_pop = q_status.valid && (!res_valid_q || res_ready);

	always_comb begin
		clr = ((q_item.kind == SEG_SYN) && (state_q != ST_SYN))
			|| ((q_item.kind == SEG_SYNACK) && (state_q != ST_SYN)
				&& (seq_origin_q != q_item.ack_m1));

		// counters bump first, a clearing segment then wipes them
		orig_pkts_d  = orig_pkts_q  + {31'd0, !q_item.rev};
		orig_data_d  = orig_data_q  + {31'd0, !q_item.rev && q_item.has_data};
		reply_pkts_d = reply_pkts_q + {31'd0, q_item.rev};
		reply_data_d = reply_data_q + {31'd0, q_item.rev && q_item.has_data};
		state_d      = state_q;
		seq_origin_d = seq_origin_q;
		ack_origin_d = ack_origin_q;
		seq_recent_d = seq_recent_q;
		ack_recent_d = ack_recent_q;
		pos_fwd_d    = pos_fwd_q;
		pos_bwd_d    = pos_bwd_q;
		win_fwd_d    = win_fwd_q;
		win_bwd_d    = win_bwd_q;
		scale_fwd_d  = scale_fwd_q;
		scale_bwd_d  = scale_bwd_q;

		if (clr) begin
			orig_pkts_d  = '0;
			orig_data_d  = '0;
			reply_pkts_d = '0;
			reply_data_d = '0;
			state_d      = ST_SYN;
			seq_origin_d = '0;
			ack_origin_d = '0;
			seq_recent_d = '0;
			ack_recent_d = '0;
			pos_fwd_d    = '0;
			pos_bwd_d    = '0;
			win_fwd_d    = '0;
			win_bwd_d    = '0;
			scale_fwd_d  = SCALE_ABSENT;
			scale_bwd_d  = SCALE_ABSENT;
		end

		case (q_item.kind)
			SEG_SYN: begin
				seq_origin_d = q_item.seq;
			end
			SEG_SYNACK: begin
				if (seq_origin_d == 32'd0) begin
					seq_origin_d = q_item.ack_m1;
				end
				ack_origin_d = q_item.seq;
			end
			SEG_CLOSE: begin
				state_d = ST_FIN;
			end
			SEG_OTHER: begin
				if (state_q == ST_SYN) begin
					state_d = ST_EST;
					if (!q_item.rev && (ack_origin_q == 32'd0)) begin
						ack_origin_d = q_item.ack_m1;
					end
				end
			end
			default: begin
			end
		endcase

		if (q_item.kind == SEG_NONTCP) begin
			// payload only: record the old position of its side as recent, then advance it
			if (q_item.rev) begin
				ack_recent_d = pos_bwd_q;
				pos_bwd_d    = pos_bwd_q + {16'd0, q_item.len};
			end else begin
				seq_recent_d = pos_fwd_q;
				pos_fwd_d    = pos_fwd_q + {16'd0, q_item.len};
			end
		end else if (q_item.rev) begin
			seq_recent_d = q_item.ack;
			pos_fwd_d    = q_item.ack;
			ack_recent_d = q_item.seq;
			pos_bwd_d    = q_item.seq + {16'd0, q_item.len};
			win_bwd_d    = q_item.win;
			if (q_item.scale != SCALE_ABSENT) begin
				scale_bwd_d = q_item.scale;
			end
		end else begin
			seq_recent_d = q_item.seq;
			pos_fwd_d    = q_item.seq + {16'd0, q_item.len};
			ack_recent_d = q_item.ack;
			pos_bwd_d    = q_item.ack;
			win_fwd_d    = q_item.win;
			if (q_item.scale != SCALE_ABSENT) begin
				scale_fwd_d = q_item.scale;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SYN;
			orig_pkts_q  <= '0;
			orig_data_q  <= '0;
			reply_pkts_q <= '0;
			reply_data_q <= '0;
			seq_origin_q <= '0;
			ack_origin_q <= '0;
			seq_recent_q <= '0;
			ack_recent_q <= '0;
			pos_fwd_q    <= '0;
			pos_bwd_q    <= '0;
			win_fwd_q    <= '0;
			win_bwd_q    <= '0;
			scale_fwd_q  <= SCALE_ABSENT;
			scale_bwd_q  <= SCALE_ABSENT;
			res_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				state_q      <= state_d;
				orig_pkts_q  <= orig_pkts_d;
				orig_data_q  <= orig_data_d;
				reply_pkts_q <= reply_pkts_d;
				reply_data_q <= reply_data_d;
				seq_origin_q <= seq_origin_d;
				ack_origin_q <= ack_origin_d;
				seq_recent_q <= seq_recent_d;
				ack_recent_q <= ack_recent_d;
				pos_fwd_q    <= pos_fwd_d;
				pos_bwd_q    <= pos_bwd_d;
				win_fwd_q    <= win_fwd_d;
				win_bwd_q    <= win_bwd_d;
				scale_fwd_q  <= scale_fwd_d;
				scale_bwd_q  <= scale_bwd_d;
				res_valid_q  <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// the result word is the track itself, held until the next segment is applied
	assign res_valid      = res_valid_q;
	assign conn_state     = state_q;
	assign initial_seq    = seq_origin_q;
	assign initial_ack    = ack_origin_q;
	assign last_seq       = seq_recent_q;
	assign last_ack       = ack_recent_q;
	assign orig_position  = pos_fwd_q;
	assign reply_position = pos_bwd_q;

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> res_valid)
		else $error("applied segment produced no result word");

	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.kind == SEG_SYN && state_q != ST_SYN
		|=> state_q == ST_SYN && orig_pkts_q == 32'd0 && reply_pkts_q == 32'd0)
		else $error("stray syn did not clear the track");

	a_close_fin: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.kind == SEG_CLOSE |=> state_q == ST_FIN)
		else $error("fin or rst did not move to fin state");

	a_nontcp_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.kind == SEG_NONTCP && !q_item.rev
		|=> seq_recent_q == $past(pos_fwd_q) && ack_origin_q == $past(ack_origin_q))
		else $error("payload-only segment disturbed the track");

endmodule

// ===== src/tcp_connection_tracker.sv =====
// top level of the single-flow tcp connection tracker
// depends on tct_pkg, tct_front, tct_back
//
//  channel  handshake             fields
//  packet   pkt_valid/pkt_ready   is_reverse is_tcp tcp_flags seq_number ack_number
//                                 window_field scale_option payload_length
//  result   res_valid/res_ready   conn_state initial_seq initial_ack last_seq last_ack
//                                 orig_position reply_position
//
// one packet word per cycle sustained while the result side keeps taking results; a result
// is registered after acceptance (queue write at the accepting edge, then the track update
// into the result register); the rate is set by the track update in the back
// a two-word queue between front and back lets either side stall on its own
// arst_n clears the track to syn state with empty counters and no window scale
module tcp_connection_tracker import tct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_ready,
	input  logic        is_reverse,
	input  logic        is_tcp,
	input  logic [7:0]  tcp_flags,
	input  logic [31:0] seq_number,
	input  logic [31:0] ack_number,
	input  logic [15:0] window_field,
	input  logic [3:0]  scale_option,
	input  logic [15:0] payload_length,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  conn_state,
	output logic [31:0] initial_seq,
	output logic [31:0] initial_ack,
	output logic [31:0] last_seq,
	output logic [31:0] last_ack,
	output logic [31:0] orig_position,
	output logic [31:0] reply_position
);

	q_status_t q_status;
	logic      q_pop;
	item_t     q_item;

	tct_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.pkt_valid      (pkt_valid),
		.pkt_ready      (pkt_ready),
		.is_reverse     (is_reverse),
		.is_tcp         (is_tcp),
		.tcp_flags      (tcp_flags),
		.seq_number     (seq_number),
		.ack_number     (ack_number),
		.window_field   (window_field),
		.scale_option   (scale_option),
		.payload_length (payload_length),
		.q_status       (q_status),
		.q_pop          (q_pop),
		.q_item         (q_item)
	);

	tct_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.q_pop          (q_pop),
		.q_item         (q_item),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.conn_state     (conn_state),
		.initial_seq    (initial_seq),
		.initial_ack    (initial_ack),
		.last_seq       (last_seq),
		.last_ack       (last_ack),
		.orig_position  (orig_position),
		.reply_position (reply_position)
	);

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for tcp_connection_tracker: single-flow packet tracking
// drives packet words with random gaps, predicts each result word and compares
// depends on tct_pkg and tcp_connection_tracker
`timescale 1ns / 1ps

module tb_top;
	import tct_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int RAND_PER_PHASE = 112;

	typedef struct packed {
		logic        rev;
		logic        tcp;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] win;
		logic [3:0]  scale;
		logic [15:0] len;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  state;
		logic [31:0] isn_orig;
		logic [31:0] isn_reply;
		logic [31:0] rec_seq;
		logic [31:0] rec_ack;
		logic [31:0] fwd_pos;
		logic [31:0] bwd_pos;
	} res_t;

	typedef struct packed {
		pkt_t pkt;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        pkt_valid;
	logic        pkt_ready;
	logic        is_reverse;
	logic        is_tcp;
	logic [7:0]  tcp_flags;
	logic [31:0] seq_number;
	logic [31:0] ack_number;
	logic [15:0] window_field;
	logic [3:0]  scale_option;
	logic [15:0] payload_length;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  conn_state;
	logic [31:0] initial_seq;
	logic [31:0] initial_ack;
	logic [31:0] last_seq;
	logic [31:0] last_ack;
	logic [31:0] orig_position;
	logic [31:0] reply_position;

	// flow state as the tracker should hold it
	conn_state_t trk_state;
	logic [31:0] orig_pkts, orig_data_pkts, reply_pkts, reply_data_pkts;
	logic [31:0] isn_orig, isn_reply, recent_seq, recent_ack;
	logic [31:0] next_orig_pos, next_reply_pos;
	logic [15:0] orig_win, reply_win;
	logic [3:0]  orig_wscale, reply_wscale;

	res_t     pending_tracks[$];
	dir_row_t dir_table[$];
	res_t     want_track;
	int       n_fail = 0;
	int       pkts_sent = 0;
	int       src_idle_pct = 0;
	int       sink_stall_pct = 0;
	int       idle_src[4] = '{0, 55, 0, 13};
	int       stall_sink[4] = '{0, 0, 55, 13};

	tcp_connection_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.pkt_valid      (pkt_valid),
		.pkt_ready      (pkt_ready),
		.is_reverse     (is_reverse),
		.is_tcp         (is_tcp),
		.tcp_flags      (tcp_flags),
		.seq_number     (seq_number),
		.ack_number     (ack_number),
		.window_field   (window_field),
		.scale_option   (scale_option),
		.payload_length (payload_length),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.conn_state     (conn_state),
		.initial_seq    (initial_seq),
		.initial_ack    (initial_ack),
		.last_seq       (last_seq),
		.last_ack       (last_ack),
		.orig_position  (orig_position),
		.reply_position (reply_position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flush_flow();
		trk_state = ST_SYN;
		orig_pkts = '0;
		orig_data_pkts = '0;
		reply_pkts = '0;
		reply_data_pkts = '0;
		isn_orig = '0;
		isn_reply = '0;
		recent_seq = '0;
		recent_ack = '0;
		next_orig_pos = '0;
		next_reply_pos = '0;
		orig_win = '0;
		reply_win = '0;
		orig_wscale = SCALE_ABSENT;
		reply_wscale = SCALE_ABSENT;
	endtask

	task automatic track_packet(input pkt_t p, output res_t r);
		logic [7:0]  kind;
		logic [31:0] ack_m1;
		kind = p.flags & FLAG_KIND_MASK;
		ack_m1 = p.ack - 32'd1;
		// counters move first, so a clearing packet is not counted
		if (p.rev) begin
			reply_pkts++;
			if (p.len != 0) reply_data_pkts++;
		end else begin
			orig_pkts++;
			if (p.len != 0) orig_data_pkts++;
		end
		if (p.tcp) begin
			if (kind == FLAG_SYN) begin
				if (trk_state != ST_SYN) flush_flow();
				isn_orig = p.seq;
			end else if (kind == (FLAG_SYN | FLAG_ACK)) begin
				if (trk_state != ST_SYN && isn_orig != ack_m1) flush_flow();
				if (isn_orig == 0) isn_orig = ack_m1;
				isn_reply = p.seq;
			end else if ((p.flags & FLAG_CLOSE) != 0) begin
				trk_state = ST_FIN;
			end else if (trk_state == ST_SYN) begin
				trk_state = ST_EST;
				if (!p.rev && isn_reply == 0) isn_reply = ack_m1;
			end
			if (p.rev) begin
				recent_seq = p.ack;
				next_orig_pos = p.ack;
				recent_ack = p.seq;
				next_reply_pos = p.seq + 32'(p.len);
				reply_win = p.win;
				if (p.scale != SCALE_ABSENT) reply_wscale = p.scale;
			end else begin
				recent_seq = p.seq;
				next_orig_pos = p.seq + 32'(p.len);
				recent_ack = p.ack;
				next_reply_pos = p.ack;
				orig_win = p.win;
				if (p.scale != SCALE_ABSENT) orig_wscale = p.scale;
			end
		end else if (p.rev) begin
			recent_ack = next_reply_pos;
			next_reply_pos = next_reply_pos + 32'(p.len);
		end else begin
			recent_seq = next_orig_pos;
			next_orig_pos = next_orig_pos + 32'(p.len);
		end
		r = '{trk_state, isn_orig, isn_reply, recent_seq, recent_ack, next_orig_pos,
			next_reply_pos};
	endtask

	function automatic pkt_t seg(input bit rev, input bit tcp, input logic [7:0] flags,
			input logic [31:0] seq, input logic [31:0] ack, input logic [15:0] len);
		pkt_t p;
		p.rev = rev;
		p.tcp = tcp;
		p.flags = flags;
		p.seq = seq;
		p.ack = ack;
		p.win = 16'($urandom_range(0, 65535));
		p.scale = ($urandom_range(0, 3) == 0) ? SCALE_ABSENT : 4'($urandom_range(0, 15));
		p.len = len;
		return p;
	endfunction

	function automatic logic [31:0] pick_isn();
		return ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
	endfunction

	function automatic logic [15:0] pick_len();
		if ($urandom_range(0, 3) == 0) return 16'd0;
		if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(1, 1460));
	endfunction

	// holds valid across the edge until the word is taken, then predicts
	task automatic send_pkt(input pkt_t p, input bit typed = 1'b0, input res_t typed_res = '0);
		res_t r;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			pkt_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		pkt_valid <= 1'b1;
		is_reverse <= p.rev;
		is_tcp <= p.tcp;
		tcp_flags <= p.flags;
		seq_number <= p.seq;
		ack_number <= p.ack;
		window_field <= p.win;
		scale_option <= p.scale;
		payload_length <= p.len;
		do @(posedge clk); while (!pkt_ready);
		track_packet(p, r);
		pending_tracks.push_back(typed ? typed_res : r);
		pkts_sent++;
	endtask

	// handshake, some data in random directions, then a close
	task automatic run_flow();
		logic [31:0] o_seq, r_seq;
		logic [15:0] len;
		logic [7:0]  flags;
		bit          fwd;
		int          n_data;
		o_seq = pick_isn();
		r_seq = pick_isn();
		send_pkt(seg(1'b0, 1'b1, FLAG_SYN, o_seq, 32'($urandom), 16'd0));
		if ($urandom_range(0, 5) == 0)
			send_pkt(seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, r_seq, 32'($urandom), 16'd0));
		else
			send_pkt(seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, r_seq, o_seq + 32'd1, 16'd0));
		o_seq++;
		r_seq++;
		send_pkt(seg(1'b0, 1'b1, FLAG_ACK, o_seq, r_seq, 16'd0));
		n_data = $urandom_range(1, 10);
		repeat (n_data) begin
			fwd = 1'($urandom_range(0, 1));
			len = pick_len();
			if ($urandom_range(0, 11) == 0) begin
				// retransmitted syn-ack, sometimes with a bad ack
				send_pkt(seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, r_seq - 32'd1,
					($urandom_range(0, 1) == 0) ? o_seq : 32'($urandom), 16'd0));
			end else if ($urandom_range(0, 4) == 0) begin
				send_pkt(seg(!fwd, 1'b0, 8'($urandom_range(0, 255)), 32'($urandom),
					32'($urandom), len));
				if (fwd) o_seq += 32'(len);
				else r_seq += 32'(len);
			end else begin
				flags = FLAG_ACK | (($urandom_range(0, 1) == 0) ? 8'h08 : 8'h00);
				if (fwd) begin
					send_pkt(seg(1'b0, 1'b1, flags, o_seq, r_seq, len));
					o_seq += 32'(len);
				end else begin
					send_pkt(seg(1'b1, 1'b1, flags, r_seq, o_seq, len));
					r_seq += 32'(len);
				end
			end
		end
		fwd = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			send_pkt(seg(!fwd, 1'b1, FLAG_RST, fwd ? o_seq : r_seq, 32'd0, 16'd0));
		end else begin
			send_pkt(seg(!fwd, 1'b1, FLAG_FIN | FLAG_ACK, fwd ? o_seq : r_seq,
				fwd ? r_seq : o_seq, 16'd0));
			send_pkt(seg(fwd, 1'b1, FLAG_FIN | FLAG_ACK, fwd ? r_seq : o_seq,
				(fwd ? o_seq : r_seq) + 32'd1, 16'd0));
			send_pkt(seg(!fwd, 1'b1, FLAG_ACK, (fwd ? o_seq : r_seq) + 32'd1,
				(fwd ? r_seq : o_seq) + 32'd1, 16'd0));
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin
		res_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (pending_tracks.size() == 0) begin
				$error("result word with no expected track");
				n_fail++;
			end else begin
				want_track = pending_tracks.pop_front();
				cmp_field("conn_state", 32'(want_track.state), 32'(conn_state));
				cmp_field("initial_seq", want_track.isn_orig, initial_seq);
				cmp_field("initial_ack", want_track.isn_reply, initial_ack);
				cmp_field("last_seq", want_track.rec_seq, last_seq);
				cmp_field("last_ack", want_track.rec_ack, last_ack);
				cmp_field("orig_position", want_track.fwd_pos, orig_position);
				cmp_field("reply_position", want_track.bwd_pos, reply_position);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pkt_valid && pkt_ready) || (res_valid && res_ready)) quiet = 0;
			else quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int goal;
		arst_n <= 1'b0;
		pkt_valid <= 1'b0;
		is_reverse <= 1'b0;
		is_tcp <= 1'b0;
		tcp_flags <= '0;
		seq_number <= '0;
		ack_number <= '0;
		window_field <= '0;
		scale_option <= SCALE_ABSENT;
		payload_length <= '0;
		flush_flow();

		// fresh track, all-ones isn, ack-1 wrap, zero as unrecorded, clears, flag masking
		dir_table.push_back('{seg(1'b0, 1'b0, 8'h00, 32'd0, 32'd0, 16'd0), 1'b1,
			'{ST_SYN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_SYN, 32'hFFFF_FFFF, 32'd0, 16'd0), 1'b1,
			'{ST_SYN, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0}});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, 32'h8000_0000, 32'd0,
			16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_ACK, 32'd0, 32'h8000_0001, 16'hFFFF),
			1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, 8'h18, 32'h8000_0001, 32'h0000_FFFF, 16'd1),
			1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
			1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b0, 8'h00, 32'd0, 32'd0, 16'hFFFF), 1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, 32'h1111_1111, 32'd0,
			16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, 32'h2222_2222,
			32'h1234_5678, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_ACK, 32'd5, 32'd0, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, 8'hFF, 32'd7, 32'd9, 16'd3), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, 8'hC2, 32'd0, 32'd0, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_ACK, 32'd1, 32'd0, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, 8'h52, 32'hABCD_EF01, 32'd1, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_RST, 32'd0, 32'hFFFF_FFFF, 16'd0),
			1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_SYN, 32'h0100_0000, 32'd0, 16'd0),
			1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_SYN, 32'h0200_0000, 32'd0, 16'd0),
			1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_ACK, 32'h0F0F_0F0F, 32'h0200_0001, 16'd4),
			1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, FLAG_FIN | FLAG_ACK, 32'h0200_0001,
			32'h0F0F_0F13, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b0, 1'b1, 8'h40, 32'h0200_0002, 32'h0F0F_0F13, 16'd0),
			1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b1, FLAG_SYN | FLAG_ACK, 32'h0F0F_0F0F,
			32'h0200_0001, 16'd0), 1'b0, '0});
		dir_table.push_back('{seg(1'b1, 1'b0, 8'h00, 32'd0, 32'd0, 16'd0), 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) send_pkt(dir_table[i].pkt, dir_table[i].typed, dir_table[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_src[ph];
			sink_stall_pct = stall_sink[ph];
			goal = pkts_sent + RAND_PER_PHASE;
			while (pkts_sent < goal) begin
				if ($urandom_range(0, 4) == 0)
					send_pkt(seg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 32'($urandom), 32'($urandom),
						16'($urandom_range(0, 65535))));
				else
					run_flow();
			end
		end
		pkt_valid <= 1'b0;

		while (pending_tracks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
